@@ rtl/assert_macros.svh @@
// Assertion macros shared by the sound DMA channel sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, quiet while reset is held.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// Implication checked on the same edge.
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the following edge.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sdma_pkg.sv @@
// Types and constants of the sound DMA channel sequencer.
`timescale 1ns / 1ps
package sdma_pkg;

    typedef enum logic [1:0] {
        OP_HBLANK    = 2'd0,
        OP_SET_ADDR  = 2'd1,
        OP_SET_PRESC = 2'd2
    } sdma_op_t;

    localparam logic CFG_CHANNEL  = 1'b0;
    localparam logic CFG_VEC_BASE = 1'b1;

    // Instruction word bit positions.
    localparam int BIT_PAUSE  = 12;
    localparam int BIT_REPEAT = 13;
    localparam int BIT_MISC   = 14;
    localparam int BIT_LOOP   = 0;
    localparam int BIT_INT    = 4;
    localparam int BIT_STOP   = 5;

    localparam logic [6:0] STATUS_BASE = 7'h40;
    localparam logic [1:0] VEC_CHAN_BASE = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] instr_word;
        logic [15:0] addr_value;
        logic [7:0]  prescaler_value;
    } sdma_in_t;

    typedef struct packed {
        logic [15:0] fetch_addr;
        logic        psg_write;
        logic [3:0]  psg_reg;
        logic [7:0]  psg_data;
        logic        int_req;
        logic [7:0]  int_vector;
        logic [6:0]  status_set_mask;
        logic        stop_req;
        logic        pausing;
    } sdma_out_t;

    typedef struct packed {
        logic        in_pause;
        logic [15:0] fetch_address;
        logic [11:0] pause_count;
        logic [7:0]  prescaler;
        logic [8:0]  prescale_count;
        logic [11:0] loop_count;
        logic [15:0] loop_address;
    } sdma_state_t;

endpackage

@@ rtl/sdma_step.sv @@
// Combinational step of the channel: next state and result for one item.
`timescale 1ns / 1ps
module sdma_step (
    input  sdma_pkg::sdma_state_t st,
    input  sdma_pkg::sdma_in_t    item,
    input  logic [1:0]            channel,
    input  logic [7:0]            vec_base,
    output sdma_pkg::sdma_state_t st_next,
    output sdma_pkg::sdma_out_t   res
);
    import sdma_pkg::*;

    logic [15:0] next_addr;
    logic [8:0]  cnt_inc;
    logic [8:0]  presc_plus;
    logic [11:0] pause_len;
    logic [11:0] pause_dec;

    always_comb
    begin
        next_addr  = {st.fetch_address[15:1], 1'b0} + 16'd2;
        cnt_inc    = st.prescale_count + 9'd1;
        presc_plus = {1'b0, st.prescaler} + 9'd1;
        pause_len  = item.instr_word[11:0];
        pause_dec  = st.pause_count - 12'd1;
        st_next    = st;
        res        = '0;

        unique case (item.opcode)
            OP_HBLANK:
            begin
                if (st.in_pause)
                begin
                    // Prescaled countdown: one pause tick per prescaler + 1 blanks.
                    if (cnt_inc >= presc_plus)
                    begin
                        st_next.prescale_count = cnt_inc - presc_plus;
                        st_next.pause_count    = pause_dec;
                        if (pause_dec == 12'd0)
                        begin
                            st_next.in_pause = 1'b0;
                        end
                    end
                    else
                    begin
                        st_next.prescale_count = cnt_inc;
                    end
                end
                else
                begin
                    st_next.fetch_address = next_addr;
                    if (item.instr_word[BIT_MISC:BIT_PAUSE] == 3'b000)
                    begin
                        res.psg_write = 1'b1;
                        res.psg_reg   = item.instr_word[11:8];
                        res.psg_data  = item.instr_word[7:0];
                    end
                    else
                    begin
                        if (item.instr_word[BIT_PAUSE])
                        begin
                            st_next.pause_count    = pause_len;
                            st_next.prescale_count = 9'd0;
                            if (pause_len == 12'd0 ||
                                (st.prescaler == 8'd0 && pause_len == 12'd1))
                            begin
                                st_next.in_pause = 1'b0;
                            end
                            else
                            begin
                                st_next.in_pause = 1'b1;
                                if (st.prescaler == 8'd0)
                                begin
                                    st_next.pause_count = pause_len - 12'd1;
                                end
                                else
                                begin
                                    st_next.prescale_count = 9'd1;
                                end
                            end
                        end
                        if (item.instr_word[BIT_REPEAT])
                        begin
                            st_next.loop_count   = pause_len;
                            st_next.loop_address = next_addr;
                        end
                        if (item.instr_word[BIT_MISC])
                        begin
                            // LOOP sees the count that a REPEAT in the same word just set.
                            if (item.instr_word[BIT_LOOP] && st_next.loop_count > 12'd1)
                            begin
                                st_next.loop_count    = st_next.loop_count - 12'd1;
                                st_next.fetch_address = st_next.loop_address;
                            end
                            if (item.instr_word[BIT_INT])
                            begin
                                res.int_req         = 1'b1;
                                res.int_vector      = {vec_base[7:3],
                                                       VEC_CHAN_BASE - channel, 1'b0};
                                res.status_set_mask = STATUS_BASE >> channel;
                            end
                            res.stop_req = item.instr_word[BIT_STOP];
                        end
                    end
                end
            end
            OP_SET_ADDR:
            begin
                st_next.fetch_address = {item.addr_value[15:1], 1'b0};
            end
            OP_SET_PRESC:
            begin
                st_next.prescaler      = item.prescaler_value;
                st_next.pause_count    = pause_dec;
                st_next.prescale_count = 9'd0;
                if (pause_dec == 12'd0)
                begin
                    st_next.in_pause = 1'b0;
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase

        res.fetch_addr = {st_next.fetch_address[15:1], 1'b0};
        res.pausing    = st_next.in_pause;
    end

endmodule

@@ rtl/sound_dma_channel_sequencer.sv @@
// Top level of one sound DMA channel sequencer.
`timescale 1ns / 1ps
// Usage:
// The item channel (item_valid / item_ready / item) carries one beat per
// horizontal blank step, fetch address write or prescaler write. For a blank
// step the beat must hold the RAM word found at the fetch_addr of the most
// recent result (or address zero after reset).
// Every item beat yields exactly one result beat on the result channel
// (result_valid / result_ready / result), in order.
// A beat accepted on the item channel sits in the item register, is then
// executed against the channel state and lands in the result register.
// Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat, the item
// register fills, and item_ready falls until the result is taken.
// The configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
// writes the channel number (index 0) or the vector base (index 1); it is
// always ready and should only be used while no item is in flight.
// Reset clears all channel state, both configuration registers and both
// pipeline valid flags; the block is ready as soon as reset is released.
module sound_dma_channel_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  sdma_pkg::sdma_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output sdma_pkg::sdma_out_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data
);
    import sdma_pkg::*;

`include "assert_macros.svh"

    sdma_in_t    item_reg;
    logic        item_valid_reg;
    sdma_out_t   result_reg;
    logic        result_valid_reg;
    sdma_state_t state_reg;
    sdma_state_t state_next;
    sdma_out_t   result_next;
    logic [1:0]  channel_reg;
    logic [7:0]  vec_base_reg;
    logic        advance;

    // The buffered item moves on whenever the result register is free or
    // is being emptied in this same cycle.
    assign advance      = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    sdma_step u_step (
        .st       (state_reg),
        .item     (item_reg),
        .channel  (channel_reg),
        .vec_base (vec_base_reg),
        .st_next  (state_next),
        .res      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
            channel_reg      <= 2'd0;
            vec_base_reg     <= 8'd0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                state_reg        <= state_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_CHANNEL:  channel_reg  <= cfg_data[1:0];
                    CFG_VEC_BASE: vec_base_reg <= cfg_data;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    `ASSERT_NEXT(a_item_buffered, clk, rst_n, item_valid && item_ready, item_valid_reg,
        "accepted item beat was not buffered")
    `ASSERT_CLK(a_presc_bound, clk, rst_n,
        state_reg.prescale_count <= {1'b0, state_reg.prescaler},
        "prescale count ran past the prescaler")
    `ASSERT_IMPLIES(a_load_not_paused, clk, rst_n, result_valid && result.psg_write,
        !result.pausing && !result.int_req && !result.stop_req,
        "LOAD result overlaps pause, interrupt or stop")
    `ASSERT_IMPLIES(a_status_mask, clk, rst_n, result_valid,
        (result.int_req && $onehot(result.status_set_mask)) ||
        (!result.int_req && result.status_set_mask == 7'd0),
        "status mask does not match the interrupt request")

endmodule
